/* hdl/msc_pkg.sv */
// ----------------------------------------------------------------------------
// msc_pkg
// Types and codes shared by the MOSI snoop coherence controller modules.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int CMD_W   = 3;
  localparam int LINE_W  = 8;
  localparam int RID_W   = 4;
  localparam int REQ_W   = 2;
  localparam int STATE_W = 3;

  // coherence states of a line
  localparam logic [STATE_W-1:0] ST_I  = 3'd0;
  localparam logic [STATE_W-1:0] ST_IS = 3'd1;
  localparam logic [STATE_W-1:0] ST_IM = 3'd2;
  localparam logic [STATE_W-1:0] ST_S  = 3'd3;
  localparam logic [STATE_W-1:0] ST_SM = 3'd4;
  localparam logic [STATE_W-1:0] ST_O  = 3'd5;
  localparam logic [STATE_W-1:0] ST_OM = 3'd6;
  localparam logic [STATE_W-1:0] ST_M  = 3'd7;

  // item commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STORE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GETS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GETM  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DATA  = 3'd4;

  // bus requests
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GETS = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GETM = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LINE_W-1:0] line_index;
    logic [RID_W-1:0]  requester_id;
  } item_t;

  typedef struct packed {
    logic [REQ_W-1:0]  bus_request;
    logic [LINE_W-1:0] line_out;
    logic              data_to_proc;
    logic              data_on_bus;
    logic [RID_W-1:0]  data_dest;
    logic              assert_shared;
    logic              miss;
    logic              protocol_error;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture item, read its table entry
    logic commit;  // write back state, load result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;  // result register holds a beat that is not taken this cycle
  } dp_stat_t;

endpackage

/* hdl/msc_ctrl.sv */
// ----------------------------------------------------------------------------
// msc_ctrl
// Sequencer: accept an item, wait in LOOKUP for the registered table read, then
// commit once the result register can take the beat.
// ----------------------------------------------------------------------------
module msc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  msc_pkg::dp_stat_t stat,
  output msc_pkg::dp_cmd_t  cmd
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_LOOKUP = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        // hold until the previous result beat leaves
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/msc_datapath.sv */
// ----------------------------------------------------------------------------
// msc_datapath
// Line state table with valid bits, item register, MOSI transition logic
// and the result register.
// ----------------------------------------------------------------------------
module msc_datapath #(
  parameter int LINES   = 256,
  parameter int MODULES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  msc_pkg::item_t    item,
  input  msc_pkg::dp_cmd_t  cmd,
  output msc_pkg::dp_stat_t stat,
  output logic              result_valid,
  input  logic              result_ready,
  output msc_pkg::result_t  result
);

  // only indexes reachable by an 8-bit line number get storage
  localparam int REACH = 1 << msc_pkg::LINE_W;
  localparam int DEPTH = (LINES < REACH) ? LINES : REACH;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // reciprocal remainder by a constant, exact for any 8-bit operand
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = msc_pkg::LINE_W + RECIP_SHIFT + 1;
  localparam int IDX_RECIP   = ((1 << RECIP_SHIFT) + DEPTH - 1) / DEPTH;
  localparam int DEST_RECIP  = ((1 << RECIP_SHIFT) + MODULES - 1) / MODULES;

  function automatic logic [msc_pkg::LINE_W-1:0] mod_const(
      input logic [msc_pkg::LINE_W-1:0] v,
      input logic [PROD_W-1:0]          recip,
      input logic [PROD_W-1:0]          m);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    logic [PROD_W-1:0] rem;
    prod = PROD_W'(v) * recip;
    quot = prod >> RECIP_SHIFT;
    rem  = PROD_W'(v) - quot * m;
    return rem[msc_pkg::LINE_W-1:0];
  endfunction

  logic [msc_pkg::STATE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            valid;
  logic [msc_pkg::STATE_W-1:0] rd_data;
  logic [IDX_W-1:0]            idx;
  msc_pkg::item_t              item_q;

  logic [IDX_W-1:0]            idx_in;
  logic [msc_pkg::LINE_W-1:0]  idx_rem;
  logic [msc_pkg::LINE_W-1:0]  dest_rem;
  logic [msc_pkg::STATE_W-1:0] st;
  logic [msc_pkg::STATE_W-1:0] nst;
  msc_pkg::result_t            res;
  logic                        is_proc;
  logic                        is_snoop;
  logic                        store;

  assign idx_rem  = mod_const(item.line_index, PROD_W'(IDX_RECIP), PROD_W'(DEPTH));
  assign idx_in   = idx_rem[IDX_W-1:0];
  assign dest_rem = mod_const({{(msc_pkg::LINE_W - msc_pkg::RID_W){1'b0}},
                               item_q.requester_id},
                              PROD_W'(DEST_RECIP), PROD_W'(MODULES));

  // an entry never written since reset reads as Invalid
  assign st = valid[idx] ? rd_data : msc_pkg::ST_I;

  assign is_proc  = (item_q.cmd == msc_pkg::CMD_LOAD) || (item_q.cmd == msc_pkg::CMD_STORE);
  assign is_snoop = (item_q.cmd == msc_pkg::CMD_GETS) || (item_q.cmd == msc_pkg::CMD_GETM)
                 || (item_q.cmd == msc_pkg::CMD_DATA);
  assign store    = (item_q.cmd == msc_pkg::CMD_STORE);

  always_comb begin
    nst                = st;
    res                = '0;
    res.line_out       = item_q.line_index;
    if (is_proc) begin
      unique case (st) inside
        msc_pkg::ST_I: begin
          res.bus_request = store ? msc_pkg::REQ_GETM : msc_pkg::REQ_GETS;
          nst             = store ? msc_pkg::ST_IM : msc_pkg::ST_IS;
          res.miss        = 1'b1;
        end
        msc_pkg::ST_IS, msc_pkg::ST_IM: begin
          res.protocol_error = 1'b1;
        end
        msc_pkg::ST_S, msc_pkg::ST_O: begin
          if (store) begin
            res.bus_request = msc_pkg::REQ_GETM;
            nst             = (st == msc_pkg::ST_S) ? msc_pkg::ST_SM : msc_pkg::ST_OM;
            res.miss        = 1'b1;
          end else begin
            res.data_to_proc = 1'b1;
          end
        end
        msc_pkg::ST_M: begin
          res.data_to_proc = 1'b1;
        end
        default: begin
          // SM and OM drop processor requests
        end
      endcase
    end else if (is_snoop) begin
      unique case (st)
        msc_pkg::ST_IS: begin
          if (item_q.cmd == msc_pkg::CMD_DATA) begin
            res.data_to_proc = 1'b1;
            nst              = msc_pkg::ST_S;
          end
        end
        msc_pkg::ST_IM: begin
          if (item_q.cmd == msc_pkg::CMD_DATA) begin
            res.data_to_proc = 1'b1;
            nst              = msc_pkg::ST_M;
          end
        end
        msc_pkg::ST_S: begin
          if (item_q.cmd == msc_pkg::CMD_GETS) begin
            res.assert_shared = 1'b1;
          end else if (item_q.cmd == msc_pkg::CMD_GETM) begin
            nst = msc_pkg::ST_I;
          end
        end
        msc_pkg::ST_SM: begin
          if (item_q.cmd == msc_pkg::CMD_GETS) begin
            res.assert_shared = 1'b1;
          end else if (item_q.cmd == msc_pkg::CMD_DATA) begin
            res.data_to_proc = 1'b1;
            nst              = msc_pkg::ST_M;
          end
        end
        msc_pkg::ST_O: begin
          if (item_q.cmd == msc_pkg::CMD_GETS) begin
            res.data_on_bus   = 1'b1;
            res.assert_shared = 1'b1;
          end else if (item_q.cmd == msc_pkg::CMD_GETM) begin
            res.data_on_bus = 1'b1;
            nst             = msc_pkg::ST_I;
          end
        end
        msc_pkg::ST_OM: begin
          // OM ignores DATA; a snooped GETM sends it back to IM
          if (item_q.cmd == msc_pkg::CMD_GETS) begin
            res.data_on_bus   = 1'b1;
            res.assert_shared = 1'b1;
          end else if (item_q.cmd == msc_pkg::CMD_GETM) begin
            res.data_on_bus   = 1'b1;
            res.assert_shared = 1'b1;
            nst               = msc_pkg::ST_IM;
          end
        end
        msc_pkg::ST_M: begin
          if (item_q.cmd == msc_pkg::CMD_GETS) begin
            res.data_on_bus   = 1'b1;
            res.assert_shared = 1'b1;
            nst               = msc_pkg::ST_O;
          end else if (item_q.cmd == msc_pkg::CMD_GETM) begin
            res.data_on_bus = 1'b1;
            nst             = msc_pkg::ST_I;
          end
        end
        default: begin
          // Invalid: nothing to snoop
        end
      endcase
    end
    if (res.data_on_bus) begin
      res.data_dest = dest_rem[msc_pkg::RID_W-1:0];
    end
  end

  // table: read on load, write back on commit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data <= mem[idx_in];
      idx     <= idx_in;
      item_q  <= item;
    end
    if (cmd.commit) begin
      mem[idx] <= nst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.commit) begin
      valid[idx] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= res;
    end
  end

  assign stat.out_busy = result_valid && !result_ready;

endmodule

/* hdl/mosi_snoop_coherence_controller.sv */
// ----------------------------------------------------------------------------
// mosi_snoop_coherence_controller
// Snooping MOSI coherence controller for one cache, one result per item.
// ----------------------------------------------------------------------------
// For each item, the accept edge reads the line's entry from the state table
// (a registered read port), and the commit edge writes the new state back and
// loads the result register. The next item is accepted only after that write
// back, so the block holds one item at a time. The result register lets an
// item enter while the previous result beat waits; the write back stalls only
// while that beat is still held. Every line starts Invalid: a valid bit per
// table entry, cleared by reset, masks entries never written, so no clearing
// pass is needed.
module mosi_snoop_coherence_controller #(
  parameter int LINES   = 256,
  parameter int MODULES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  msc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output msc_pkg::result_t result
);

  msc_pkg::dp_cmd_t  dp_cmd;
  msc_pkg::dp_stat_t dp_stat;

  msc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  msc_datapath #(
    .LINES   (LINES),
    .MODULES (MODULES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* hdl/msc_checker.sv */
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks of the coherence controller, bound to the top level.
// ----------------------------------------------------------------------------
module msc_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input msc_pkg::result_t result
);

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // one item at a time: the table write back blocks the next accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted during table lookup");

  // an error result carries no other strobe
  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.protocol_error |->
      result.bus_request == msc_pkg::REQ_NONE && !result.data_to_proc &&
      !result.data_on_bus && !result.assert_shared && !result.miss)
    else $error("protocol error combined with other strobes");

  // a miss always goes out as a bus request, and only a miss does
  a_miss_request: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.miss == (result.bus_request != msc_pkg::REQ_NONE)))
    else $error("miss and bus request disagree");

  // no supplied data, no destination
  a_dest_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.data_on_bus |-> result.data_dest == '0)
    else $error("data destination set without bus data");

endmodule

bind mosi_snoop_coherence_controller msc_checker u_msc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

/* verif/msc_coherence_checker.sv */
// ----------------------------------------------------------------------------
// msc_coherence_checker
// Watches both channels of the MOSI snoop coherence controller, keeps its own
// copy of the per-line coherence table, predicts the response to every
// accepted item and compares each result beat, field by field, in order.
// ----------------------------------------------------------------------------
module msc_coherence_checker #(
  parameter int LINES   = 256,
  parameter int MODULES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  msc_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_ready,
  input  msc_pkg::result_t result,
  output int               fail_count,
  output int               pending
);

  logic [msc_pkg::STATE_W-1:0] coh_state [LINES];
  msc_pkg::result_t            response_q[$];

  // Apply one item to the shadow table and return the response it causes.
  function automatic msc_pkg::result_t snoop_response(input msc_pkg::item_t it);
    int                          idx;
    logic [msc_pkg::STATE_W-1:0] st;
    logic [msc_pkg::STATE_W-1:0] nst;
    msc_pkg::result_t            r;
    logic                        is_store;
    idx      = int'(it.line_index) % LINES;
    st       = coh_state[idx];
    nst      = st;
    r        = '0;
    r.line_out = it.line_index;
    is_store = (it.cmd == msc_pkg::CMD_STORE);
    if (it.cmd == msc_pkg::CMD_LOAD || it.cmd == msc_pkg::CMD_STORE) begin
      case (st)
        msc_pkg::ST_I: begin
          r.bus_request = is_store ? msc_pkg::REQ_GETM : msc_pkg::REQ_GETS;
          nst           = is_store ? msc_pkg::ST_IM : msc_pkg::ST_IS;
          r.miss        = 1'b1;
        end
        msc_pkg::ST_IS, msc_pkg::ST_IM: r.protocol_error = 1'b1;
        msc_pkg::ST_S, msc_pkg::ST_O: begin
          if (is_store) begin
            r.bus_request = msc_pkg::REQ_GETM;
            nst           = (st == msc_pkg::ST_S) ? msc_pkg::ST_SM : msc_pkg::ST_OM;
            r.miss        = 1'b1;
          end else begin
            r.data_to_proc = 1'b1;
          end
        end
        msc_pkg::ST_M: r.data_to_proc = 1'b1;
        default: ;  // upgrade in flight: drop the request quietly
      endcase
    end else if (it.cmd == msc_pkg::CMD_GETS || it.cmd == msc_pkg::CMD_GETM ||
                 it.cmd == msc_pkg::CMD_DATA) begin
      case (st)
        msc_pkg::ST_IS: begin
          if (it.cmd == msc_pkg::CMD_DATA) begin
            r.data_to_proc = 1'b1;
            nst            = msc_pkg::ST_S;
          end
        end
        msc_pkg::ST_IM: begin
          if (it.cmd == msc_pkg::CMD_DATA) begin
            r.data_to_proc = 1'b1;
            nst            = msc_pkg::ST_M;
          end
        end
        msc_pkg::ST_S: begin
          if (it.cmd == msc_pkg::CMD_GETS) r.assert_shared = 1'b1;
          else if (it.cmd == msc_pkg::CMD_GETM) nst = msc_pkg::ST_I;
        end
        msc_pkg::ST_SM: begin
          if (it.cmd == msc_pkg::CMD_GETS) begin
            r.assert_shared = 1'b1;
          end else if (it.cmd == msc_pkg::CMD_DATA) begin
            r.data_to_proc = 1'b1;
            nst            = msc_pkg::ST_M;
          end
        end
        msc_pkg::ST_O: begin
          if (it.cmd == msc_pkg::CMD_GETS) begin
            r.data_on_bus   = 1'b1;
            r.assert_shared = 1'b1;
          end else if (it.cmd == msc_pkg::CMD_GETM) begin
            r.data_on_bus = 1'b1;
            nst           = msc_pkg::ST_I;
          end
        end
        msc_pkg::ST_OM: begin
          // OM ignores DATA and falls back to IM on a foreign GETM
          if (it.cmd == msc_pkg::CMD_GETS) begin
            r.data_on_bus   = 1'b1;
            r.assert_shared = 1'b1;
          end else if (it.cmd == msc_pkg::CMD_GETM) begin
            r.data_on_bus   = 1'b1;
            r.assert_shared = 1'b1;
            nst             = msc_pkg::ST_IM;
          end
        end
        msc_pkg::ST_M: begin
          if (it.cmd == msc_pkg::CMD_GETS) begin
            r.data_on_bus   = 1'b1;
            r.assert_shared = 1'b1;
            nst             = msc_pkg::ST_O;
          end else if (it.cmd == msc_pkg::CMD_GETM) begin
            r.data_on_bus = 1'b1;
            nst           = msc_pkg::ST_I;
          end
        end
        default: ;
      endcase
    end
    if (r.data_on_bus) r.data_dest = msc_pkg::RID_W'(int'(it.requester_id) % MODULES);
    coh_state[idx] = nst;
    return r;
  endfunction

  function automatic void note_field(input string name, input logic [7:0] exp_v,
                                     input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %0h, got %0h (t=%0t)", name, exp_v, got_v, $time);
    end
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    msc_pkg::result_t exp_r;
    if (rst) begin
      for (int i = 0; i < LINES; i++) coh_state[i] = msc_pkg::ST_I;
      response_q.delete();
    end else begin
      // retire the result beat first: it always belongs to an older item
      if (result_valid && result_ready) begin
        if (response_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat %h (t=%0t)", result, $time);
        end else begin
          exp_r = response_q.pop_front();
          note_field("bus_request",    8'(exp_r.bus_request),    8'(result.bus_request));
          note_field("line_out",       8'(exp_r.line_out),       8'(result.line_out));
          note_field("data_to_proc",   8'(exp_r.data_to_proc),   8'(result.data_to_proc));
          note_field("data_on_bus",    8'(exp_r.data_on_bus),    8'(result.data_on_bus));
          note_field("data_dest",      8'(exp_r.data_dest),      8'(result.data_dest));
          note_field("assert_shared",  8'(exp_r.assert_shared),  8'(result.assert_shared));
          note_field("miss",           8'(exp_r.miss),           8'(result.miss));
          note_field("protocol_error", 8'(exp_r.protocol_error), 8'(result.protocol_error));
        end
      end
      if (item_valid && item_ready) response_q.push_back(snoop_response(item));
    end
    pending = response_q.size();
  end

endmodule

/* verif/tb_mosi_snoop_coherence_controller.sv */
// ----------------------------------------------------------------------------
// tb_mosi_snoop_coherence_controller
// Drives processor requests and snooped bus messages into the coherence
// controller with random gaps and result stalls; a checker beside the block
// predicts and compares every result beat. Directed walk through all line
// states first, then random traffic concentrated on a few hot lines.
// ----------------------------------------------------------------------------
module tb_mosi_snoop_coherence_controller;

  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 400000;

  // a command code outside the defined set
  localparam logic [msc_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_ready;
  msc_pkg::item_t   item;
  logic             result_valid;
  logic             result_ready;
  msc_pkg::result_t result;
  int               fail_count;
  int               pending;
  logic             calm;
  int               stall_left;
  logic [msc_pkg::LINE_W-1:0] hot_lines[8];

  mosi_snoop_coherence_controller i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  msc_coherence_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one beat and hold it until it is taken.
  task automatic send(input logic [msc_pkg::CMD_W-1:0] cmd,
                      input logic [msc_pkg::LINE_W-1:0] line,
                      input logic [msc_pkg::RID_W-1:0] rid);
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= '{cmd: cmd, line_index: line, requester_id: rid};
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic idle(input int n);
    repeat (n) @(negedge clk) item_valid <= 1'b0;
  endtask

  // Stall the result side at random, except during calm stretches.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else begin
      result_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL mosi_snoop_coherence_controller");
    $finish;
  end

  initial begin
    int                         sent;
    logic [msc_pkg::CMD_W-1:0]  cmd;
    logic [msc_pkg::LINE_W-1:0] line;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    calm         = 1'b0;
    stall_left   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // walk line 0 through every state, poking each command along the way
    send(msc_pkg::CMD_LOAD,  8'd0, 4'd0);    // I -> IS, miss
    send(msc_pkg::CMD_LOAD,  8'd0, 4'd0);    // pending miss: error
    send(msc_pkg::CMD_STORE, 8'd0, 4'd0);
    send(msc_pkg::CMD_GETS,  8'd0, 4'd15);   // ignored while IS
    send(msc_pkg::CMD_DATA,  8'd0, 4'd3);    // IS -> S
    send(msc_pkg::CMD_LOAD,  8'd0, 4'd0);    // hit
    send(msc_pkg::CMD_GETS,  8'd0, 4'd9);    // assert shared
    send(msc_pkg::CMD_STORE, 8'd0, 4'd0);    // S -> SM
    send(msc_pkg::CMD_LOAD,  8'd0, 4'd0);    // dropped during upgrade
    send(msc_pkg::CMD_GETS,  8'd0, 4'd6);
    send(msc_pkg::CMD_GETM,  8'd0, 4'd6);    // ignored while SM
    send(msc_pkg::CMD_DATA,  8'd0, 4'd0);    // SM -> M
    send(msc_pkg::CMD_LOAD,  8'd0, 4'd0);
    send(msc_pkg::CMD_GETS,  8'd0, 4'd15);   // M -> O, supply data
    send(msc_pkg::CMD_LOAD,  8'd0, 4'd0);
    send(msc_pkg::CMD_GETS,  8'd0, 4'd10);
    send(msc_pkg::CMD_STORE, 8'd0, 4'd0);    // O -> OM
    send(msc_pkg::CMD_STORE, 8'd0, 4'd0);
    send(msc_pkg::CMD_DATA,  8'd0, 4'd0);    // OM keeps ignoring DATA
    send(msc_pkg::CMD_GETS,  8'd0, 4'd5);
    send(msc_pkg::CMD_GETM,  8'd0, 4'd12);   // OM -> IM
    send(msc_pkg::CMD_DATA,  8'd0, 4'd0);    // IM -> M
    send(msc_pkg::CMD_GETM,  8'd0, 4'd15);   // M -> I
    send(msc_pkg::CMD_STORE, 8'd255, 4'd15); // I -> IM at the top line
    send(CMD_UNUSED,         8'd255, 4'd15);
    idle(1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 200 == 0)
        foreach (hot_lines[i]) hot_lines[i] = msc_pkg::LINE_W'($urandom_range(0, 255));
      if (sent % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 95) cmd = msc_pkg::CMD_W'($urandom_range(0, 4));
      else cmd = msc_pkg::CMD_W'($urandom_range(5, 7));
      if ($urandom_range(0, 99) < 85) line = hot_lines[$urandom_range(0, 7)];
      else line = msc_pkg::LINE_W'($urandom_range(0, 255));
      send(cmd, line, msc_pkg::RID_W'($urandom_range(0, 15)));
      if (cmd <= msc_pkg::CMD_DATA) sent++;
      if (!calm) idle(pick_gap());
    end
    idle(1);
    calm = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("PASS mosi_snoop_coherence_controller");
    else $display("FAIL mosi_snoop_coherence_controller");
    $finish;
  end

endmodule

/* mosi_snoop_coherence_controller.f */
hdl/msc_pkg.sv
hdl/msc_ctrl.sv
hdl/msc_datapath.sv
hdl/mosi_snoop_coherence_controller.sv
hdl/msc_checker.sv
verif/msc_coherence_checker.sv
verif/tb_mosi_snoop_coherence_controller.sv
